/* rtl/gmdfs_pkg.sv */
package gmdfs_pkg;

    // operation codes carried on s_axis_tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GRID_SIZE  = 3'd0;
    localparam logic [2:0] CFG_SOURCE_ROW = 3'd1;
    localparam logic [2:0] CFG_SOURCE_COL = 3'd2;
    localparam logic [2:0] CFG_TARGET_ROW = 3'd3;
    localparam logic [2:0] CFG_TARGET_COL = 3'd4;

    // walk directions, tried in this order
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_CLEAR = 9'b000000100,
        ST_START = 9'b000001000,
        ST_EVAL  = 9'b000010000,
        ST_PROBE = 9'b000100000,
        ST_CHECK = 9'b001000000,
        ST_POP   = 9'b010000000,
        ST_POPW  = 9'b100000000
    } state_t;

endpackage

/* rtl/gmdfs_map.sv */
module gmdfs_map #(
    parameter int AW = 8,
    parameter int DEPTH = 256
) (
    input  logic          aclk,
    input  logic          open_we,
    input  logic [AW-1:0] open_addr,
    input  logic          open_wdata,
    input  logic          vis_we,
    input  logic [AW-1:0] vis_addr,
    input  logic          vis_wdata,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_open,
    output logic          rd_visited
);
    logic open_mem [DEPTH];
    logic vis_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (open_we) begin
            open_mem[open_addr] <= open_wdata;
        end
        rd_open <= open_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_addr] <= vis_wdata;
        end
        rd_visited <= vis_mem[rd_addr];
    end

endmodule

/* rtl/gmdfs_stack.sv */
module gmdfs_stack #(
    parameter int AW = 8,
    parameter int DEPTH = 256,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_maze_dfs_path_finder.sv */
// Depth-first path finder on a square grid of up to GRID_MAX x GRID_MAX cells.
// Beats on the slave side carry an operation in s_axis_tuser: load one cell's
// open/wall bit, run a search from the source to the target cell, or read the
// next cell of the found path. Every input beat yields exactly one result beat
// with the found flag and path length; read beats also carry the path cell,
// with tuser marking a valid cell and tlast marking the target. Load beats and
// unused codes are answered straight from idle; read beats first pass through
// ST_READ for a synchronous stack read. A search first sweeps the whole
// visited map, one cell a cycle (all GRID_MAX*GRID_MAX cells), then walks:
// each probe of a neighbour inside the grid is one map read (PROBE) plus a
// check (CHECK), a neighbour off the grid is skipped, the target next door
// is pushed without a probe, and a backtrack passes POP and POPW for the
// stack read. Each cell is evaluated once on arrival and once more after
// each child backtracks. The walk runs out of memories with one write and
// one read port: open/visited maps and the coordinate stack. The open map
// holds whatever was loaded; cells never loaded read as garbage.
// Configuration is written by the user through cfg_we/cfg_addr/cfg_wdata
// only while idle; the block does not enforce it.
module grid_maze_dfs_path_finder #(
    parameter int GRID_MAX = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_addr,
    input  logic [4:0]                        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_row[3:0], cell_col[7:4], cell_open[8], zero fill
    input  logic [gmdfs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // path_found[0], path_length[9:1], step_row[13:10], step_col[17:14], zero fill
    output logic [gmdfs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // step_valid[0]
    output logic [0:0]                        m_axis_tuser,
    // step_last
    output logic                              m_axis_tlast
);
    import gmdfs_pkg::*;

    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_MAX);
    localparam int DW    = $clog2(CELLS + 1);
    // compare width: holds the 5-bit grid size, GRID_MAX and a coordinate + 1
    localparam int CMP_W = ($clog2(GRID_MAX + 1) > 5 ? $clog2(GRID_MAX + 1) : 5) + 1;

    state_t          st_reg, st_next;
    logic [4:0]      gs_reg, gs_next;
    logic [3:0]      sr_reg, sr_next, sc_reg, sc_next;
    logic [3:0]      tr_reg, tr_next, tc_reg, tc_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [DW-1:0]   rp_reg, rp_next;
    logic            found_reg, found_next;
    logic            oob_reg, oob_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [1:0]      dir_reg, dir_next;
    logic [CW-1:0]   ty_reg, ty_next, tx_reg, tx_next;
    logic            ov_reg, ov_next;
    logic [3:0]      orow_reg, orow_next, ocol_reg, ocol_next;
    logic            osv_reg, osv_next, olast_reg, olast_next;

    // memory ports
    logic            open_we, vis_we, vis_wdata, stk_we;
    logic [AW-1:0]   open_addr, vis_addr, map_raddr, stk_waddr, stk_raddr;
    logic [2*CW-1:0] stk_wdata, stk_rdata;
    logic            rd_open, rd_visited;

    // decoded beat
    logic [1:0]      in_op;
    logic [3:0]      in_row, in_col;
    logic            in_open, in_acc;

    // walk helpers
    logic [CMP_W-1:0] n_live, ye, xe, tre, tce;
    logic [CW-1:0]    tr_c, tc_c, nb_y, nb_x;
    logic             at_target, adj_target, nb_ok;
    logic [31:0]      len32;

    assign in_op   = s_axis_tuser;
    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_open = s_axis_tdata[8];

    assign s_axis_tready = (st_reg == ST_IDLE) && (!ov_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign len32         = found_reg ? 32'(depth_reg) : 32'd0;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, ocol_reg, orow_reg, len32[8:0], found_reg};
    assign m_axis_tuser  = osv_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb begin
        if (gs_reg == 5'd0) begin
            n_live = CMP_W'(1);
        end else if (32'(gs_reg) > GRID_MAX) begin
            n_live = CMP_W'(GRID_MAX);
        end else begin
            n_live = CMP_W'(gs_reg);
        end
    end

    assign tr_c = CW'(tr_reg);
    assign tc_c = CW'(tc_reg);
    assign ye   = CMP_W'(ty_reg);
    assign xe   = CMP_W'(tx_reg);
    assign tre  = CMP_W'(tr_c);
    assign tce  = CMP_W'(tc_c);

    assign at_target  = (ty_reg == tr_c) && (tx_reg == tc_c);
    assign adj_target = ((ye + 1'b1 == tre) && (xe == tce)) ||
                        ((ye == tre + 1'b1) && (xe == tce)) ||
                        ((ye == tre) && (xe + 1'b1 == tce)) ||
                        ((ye == tre) && (xe == tce + 1'b1));

    always_comb begin
        nb_y  = ty_reg;
        nb_x  = tx_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_RIGHT: begin
                nb_x  = tx_reg + 1'b1;
                nb_ok = (xe + 1'b1) < n_live;
            end
            DIR_LEFT: begin
                nb_x  = tx_reg - 1'b1;
                nb_ok = xe != '0;
            end
            DIR_UP: begin
                nb_y  = ty_reg - 1'b1;
                nb_ok = ye != '0;
            end
            DIR_DOWN: begin
                nb_y  = ty_reg + 1'b1;
                nb_ok = (ye + 1'b1) < n_live;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign map_raddr = AW'(32'(nb_y) * GRID_MAX + 32'(nb_x));

    always_comb begin
        st_next    = st_reg;
        gs_next    = gs_reg;
        sr_next    = sr_reg;
        sc_next    = sc_reg;
        tr_next    = tr_reg;
        tc_next    = tc_reg;
        depth_next = depth_reg;
        rp_next    = rp_reg;
        found_next = found_reg;
        oob_next   = oob_reg;
        clr_next   = clr_reg;
        dir_next   = dir_reg;
        ty_next    = ty_reg;
        tx_next    = tx_reg;
        ov_next    = ov_reg && !m_axis_tready;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        osv_next   = osv_reg;
        olast_next = olast_reg;

        open_we    = 1'b0;
        open_addr  = AW'(32'(in_row) * GRID_MAX + 32'(in_col));
        vis_we     = 1'b0;
        vis_addr   = clr_reg;
        vis_wdata  = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = AW'(depth_reg);
        stk_wdata  = {ty_reg, tx_reg};
        stk_raddr  = AW'(rp_reg);

        if (cfg_we) begin
            case (cfg_addr)
                CFG_GRID_SIZE:  gs_next = cfg_wdata;
                CFG_SOURCE_ROW: sr_next = cfg_wdata[3:0];
                CFG_SOURCE_COL: sc_next = cfg_wdata[3:0];
                CFG_TARGET_ROW: tr_next = cfg_wdata[3:0];
                CFG_TARGET_COL: tc_next = cfg_wdata[3:0];
                default: ;
            endcase
        end

        case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    orow_next  = 4'd0;
                    ocol_next  = 4'd0;
                    osv_next   = 1'b0;
                    olast_next = 1'b0;
                    case (in_op)
                        OP_LOAD: begin
                            open_we = (32'(in_row) < GRID_MAX) && (32'(in_col) < GRID_MAX);
                            ov_next = 1'b1;
                        end
                        OP_SEARCH: begin
                            found_next = 1'b0;
                            depth_next = '0;
                            rp_next    = '0;
                            clr_next   = '0;
                            oob_next   = (CMP_W'(sr_reg) >= n_live) ||
                                         (CMP_W'(sc_reg) >= n_live) ||
                                         (CMP_W'(tr_reg) >= n_live) ||
                                         (CMP_W'(tc_reg) >= n_live);
                            st_next    = ST_CLEAR;
                        end
                        OP_READ: begin
                            if (found_reg && (rp_reg < depth_reg)) begin
                                st_next = ST_READ;
                            end else begin
                                ov_next = 1'b1;
                            end
                        end
                        default: begin
                            ov_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                orow_next  = 4'(stk_rdata[2*CW-1:CW]);
                ocol_next  = 4'(stk_rdata[CW-1:0]);
                osv_next   = 1'b1;
                olast_next = (rp_reg + 1'b1) == depth_reg;
                rp_next    = rp_reg + 1'b1;
                ov_next    = 1'b1;
                st_next    = ST_IDLE;
            end
            ST_CLEAR: begin
                // sweep the visited map clear
                vis_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CELLS - 1) begin
                    if (oob_reg) begin
                        ov_next = 1'b1;
                        st_next = ST_IDLE;
                    end else begin
                        st_next = ST_START;
                    end
                end
            end
            ST_START: begin
                vis_we     = 1'b1;
                vis_wdata  = 1'b1;
                vis_addr   = AW'(32'(sr_reg) * GRID_MAX + 32'(sc_reg));
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {CW'(sr_reg), CW'(sc_reg)};
                depth_next = DW'(1);
                ty_next    = CW'(sr_reg);
                tx_next    = CW'(sc_reg);
                st_next    = ST_EVAL;
            end
            ST_EVAL: begin
                if (at_target) begin
                    found_next = 1'b1;
                    ov_next    = 1'b1;
                    st_next    = ST_IDLE;
                end else if (adj_target) begin
                    // destination next door: step onto it without a probe
                    if (32'(depth_reg) < CELLS) begin
                        stk_we     = 1'b1;
                        stk_wdata  = {tr_c, tc_c};
                        depth_next = depth_reg + 1'b1;
                        ty_next    = tr_c;
                        tx_next    = tc_c;
                    end
                end else begin
                    dir_next = DIR_RIGHT;
                    st_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (nb_ok) begin
                    st_next = ST_CHECK;
                end else if (dir_reg == DIR_DOWN) begin
                    st_next = ST_POP;
                end else begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            ST_CHECK: begin
                if (rd_open && !rd_visited) begin
                    vis_we    = 1'b1;
                    vis_wdata = 1'b1;
                    vis_addr  = map_raddr;
                    if (32'(depth_reg) < CELLS) begin
                        stk_we     = 1'b1;
                        stk_wdata  = {nb_y, nb_x};
                        depth_next = depth_reg + 1'b1;
                    end
                    ty_next = nb_y;
                    tx_next = nb_x;
                    st_next = ST_EVAL;
                end else if (dir_reg == DIR_DOWN) begin
                    st_next = ST_POP;
                end else begin
                    dir_next = dir_reg + 1'b1;
                    st_next  = ST_PROBE;
                end
            end
            ST_POP: begin
                depth_next = depth_reg - 1'b1;
                stk_raddr  = AW'(depth_reg - DW'(2));
                if (depth_reg == DW'(1)) begin
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end else begin
                    st_next = ST_POPW;
                end
            end
            ST_POPW: begin
                ty_next = stk_rdata[2*CW-1:CW];
                tx_next = stk_rdata[CW-1:0];
                st_next = ST_EVAL;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            gs_reg    <= 5'd16;
            sr_reg    <= 4'd0;
            sc_reg    <= 4'd0;
            tr_reg    <= 4'd15;
            tc_reg    <= 4'd15;
            depth_reg <= '0;
            rp_reg    <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            gs_reg    <= gs_next;
            sr_reg    <= sr_next;
            sc_reg    <= sc_next;
            tr_reg    <= tr_next;
            tc_reg    <= tc_next;
            depth_reg <= depth_next;
            rp_reg    <= rp_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        oob_reg   <= oob_next;
        clr_reg   <= clr_next;
        dir_reg   <= dir_next;
        ty_reg    <= ty_next;
        tx_reg    <= tx_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        osv_reg   <= osv_next;
        olast_reg <= olast_next;
    end

    gmdfs_map #(
        .AW    (AW),
        .DEPTH (CELLS)
    ) u_map (
        .aclk       (aclk),
        .open_we    (open_we),
        .open_addr  (open_addr),
        .open_wdata (in_open),
        .vis_we     (vis_we),
        .vis_addr   (vis_addr),
        .vis_wdata  (vis_wdata),
        .rd_addr    (map_raddr),
        .rd_open    (rd_open),
        .rd_visited (rd_visited)
    );

    gmdfs_stack #(
        .AW    (AW),
        .DEPTH (CELLS),
        .DW    (2 * CW)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= CELLS)
        else $error("stack depth beyond grid");
    a_found_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> depth_reg != '0)
        else $error("found with empty path");
    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_READ |-> !ov_reg)
        else $error("read result would overwrite held beat");
    a_rp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> rp_reg <= depth_reg)
        else $error("read pointer past path end");
    a_search_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EVAL && at_target) |=> found_reg && ov_reg)
        else $error("target reached but no result");
`endif

endmodule
